/* rtl/alu_pkg.sv */
// ----------------------------------------------------------------------------
// alu_pkg: shared types and codes for the integer ALU with condition flags
// Item and result structs, operation codes, flag bit positions.
// ----------------------------------------------------------------------------
`default_nettype none
package alu_pkg;

  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_ABCD  = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_AND   = 5'd3;
  localparam logic [4:0] OP_EOR   = 5'd4;
  localparam logic [4:0] OP_ADDA  = 5'd5;
  localparam logic [4:0] OP_ADDQ  = 5'd6;
  localparam logic [4:0] OP_ADDX  = 5'd7;
  localparam logic [4:0] OP_ANDCC = 5'd8;
  localparam logic [4:0] OP_ANDSR = 5'd9;
  localparam logic [4:0] OP_ASL   = 5'd10;
  localparam logic [4:0] OP_ASR   = 5'd11;
  localparam logic [4:0] OP_LSL   = 5'd12;
  localparam logic [4:0] OP_LSR   = 5'd13;
  localparam logic [4:0] OP_BCC   = 5'd14;
  localparam logic [4:0] OP_BSR   = 5'd15;
  localparam logic [4:0] OP_BTST  = 5'd16;
  localparam logic [4:0] OP_BCHG  = 5'd17;
  localparam logic [4:0] OP_BCLR  = 5'd18;
  localparam logic [4:0] OP_BSET  = 5'd19;
  localparam logic [4:0] OP_CLR   = 5'd20;
  localparam logic [4:0] OP_NEG   = 5'd21;
  localparam logic [4:0] OP_NEGX  = 5'd22;
  localparam logic [4:0] OP_NOT   = 5'd23;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] DK_DREG = 2'd0;
  localparam logic [1:0] DK_AREG = 2'd1;

  localparam int FC = 0;
  localparam int FV = 1;
  localparam int FZ = 2;
  localparam int FN = 3;
  localparam int FX = 4;

  // operation classes chosen by the front part
  localparam logic [2:0] CL_NONE   = 3'd0;
  localparam logic [2:0] CL_SIMPLE = 3'd1;
  localparam logic [2:0] CL_SHIFT  = 3'd2;
  localparam logic [2:0] CL_BRANCH = 3'd3;
  localparam logic [2:0] CL_BIT    = 3'd4;

  typedef struct packed {
    logic [4:0]  operation;
    logic [1:0]  size_code;
    logic [31:0] source_value;
    logic [31:0] dest_value;
    logic        count_from_register;
    logic [15:0] immediate_data;
    logic [3:0]  condition_code;
    logic [31:0] program_counter;
    logic [1:0]  dest_kind;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        result_write;
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        unaligned_pc;
    logic [15:0] status_out;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    in_item_t    item;
    logic [2:0]  op_class;
    logic [31:0] mask;
    logic [31:0] top;
    logic [5:0]  shift_count;
  } dec_item_t;

endpackage
`default_nettype wire

/* rtl/alu_front.sv */
// ----------------------------------------------------------------------------
// alu_front: accept and classify items
// Works out operand mask, sign bit, shift count and class; feeds a 2-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module alu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire alu_pkg::in_item_t in_item,
  input  wire logic              push,
  output logic                   full,
  output alu_pkg::dec_item_t     dec_item,
  output logic                   dec_valid,
  input  wire logic              dec_take
);

  alu_pkg::dec_item_t q [2];
  logic               rd_ptr;
  logic               wr_ptr;
  logic [1:0]         count;
  alu_pkg::dec_item_t cls;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    cls = '0;
    cls.item = in_item;
    unique case (in_item.size_code)
      alu_pkg::SZ_BYTE: begin
        cls.mask = 32'h0000_00FF;
        cls.top  = 32'h0000_0080;
      end
      alu_pkg::SZ_WORD: begin
        cls.mask = 32'h0000_FFFF;
        cls.top  = 32'h0000_8000;
      end
      default: begin
        cls.mask = 32'hFFFF_FFFF;
        cls.top  = 32'h8000_0000;
      end
    endcase
    // an immediate low-byte count above 63 gives the same value and flags as 63:
    // every operand bit is out well before that, so cap it there
    if (in_item.count_from_register) begin
      cls.shift_count = in_item.source_value[5:0];
    end else if (in_item.immediate_data == 16'd0) begin
      cls.shift_count = 6'd8;
    end else if (in_item.immediate_data[7:6] != 2'd0) begin
      cls.shift_count = 6'd63;
    end else begin
      cls.shift_count = in_item.immediate_data[5:0];
    end
    priority if (in_item.operation >= alu_pkg::OP_ASL &&
                 in_item.operation <= alu_pkg::OP_LSR) begin
      cls.op_class = alu_pkg::CL_SHIFT;
    end else if (in_item.operation == alu_pkg::OP_BCC ||
                 in_item.operation == alu_pkg::OP_BSR) begin
      cls.op_class = alu_pkg::CL_BRANCH;
    end else if (in_item.operation >= alu_pkg::OP_BTST &&
                 in_item.operation <= alu_pkg::OP_BSET) begin
      cls.op_class = alu_pkg::CL_BIT;
    end else if (in_item.operation == alu_pkg::OP_NOP ||
                 in_item.operation > alu_pkg::OP_NOT) begin
      cls.op_class = alu_pkg::CL_NONE;
    end else begin
      cls.op_class = alu_pkg::CL_SIMPLE;
    end
  end

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign do_pop    = dec_take && (count != 2'd0);
  assign dec_valid = (count != 2'd0);
  assign dec_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* rtl/alu_back.sv */
// ----------------------------------------------------------------------------
// alu_back: carry out one classified item, keep the status register
// Shifts iterate one bit per cycle; everything else is worked out combinationally and registered into the result.
// ----------------------------------------------------------------------------
`default_nettype none
module alu_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire alu_pkg::dec_item_t dec_item,
  input  wire logic               dec_valid,
  output logic                    dec_take,
  output alu_pkg::out_item_t      out_item,
  output logic                    empty,
  input  wire logic               pop
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0]         state;
  logic [15:0]        sr;
  logic [15:0]        sr_next;
  alu_pkg::dec_item_t cur;
  logic [31:0]        sh_val;
  logic [5:0]         sh_left;
  logic               sh_ov;
  logic               sh_last;
  alu_pkg::out_item_t res;
  alu_pkg::out_item_t res_next;

  logic [31:0] s, d, m, t, r;
  logic [32:0] sum;
  logic        xin, cond, dreg;
  logic [4:0]  bn;
  logic [31:0] bitm, val, nv;
  logic [8:0]  bin;
  logic [4:0]  lo;
  logic [5:0]  hi;
  logic        bcarry;
  logic [31:0] off;
  logic [31:0] adda_src;
  logic [31:0] nshift;
  logic        nmsb;
  logic [31:0] rm;
  logic        zero_r;

  // one shift step on the working value
  always_comb begin
    nshift = cur.item.operation == alu_pkg::OP_ASL || cur.item.operation == alu_pkg::OP_LSL
           ? {sh_val[30:0], 1'b0}
           : (cur.item.operation == alu_pkg::OP_ASR
              ? ((sh_val[31:0] >> 1) | (sh_val[31:0] & cur.top)) : (sh_val[31:0] >> 1));
    nshift = nshift & cur.mask;
    nmsb   = (nshift & cur.top) != 32'd0;
  end

  always_comb begin
    s    = dec_item.item.source_value & dec_item.mask;
    d    = dec_item.item.dest_value & dec_item.mask;
    m    = dec_item.mask;
    t    = dec_item.top;
    xin  = sr[alu_pkg::FX];
    sr_next  = sr;
    res_next = '0;
    res_next.next_pc = dec_item.item.program_counter;
    r   = '0;
    sum = '0;
    bin = '0; lo = '0; hi = '0; bcarry = 1'b0;
    cond = 1'b0; off = '0; adda_src = '0;
    dreg = dec_item.item.dest_kind == alu_pkg::DK_DREG;
    bn   = dreg ? dec_item.item.source_value[4:0] : {2'b00, dec_item.item.source_value[2:0]};
    bitm = 32'd1 << bn;
    val  = dreg ? dec_item.item.dest_value : {24'd0, dec_item.item.dest_value[7:0]};
    nv   = val;
    rm   = '0;
    zero_r = 1'b0;
    unique case (dec_item.item.operation)
      alu_pkg::OP_ABCD: begin
        bin = {1'b0, dec_item.item.source_value[7:0]} + {1'b0, dec_item.item.dest_value[7:0]}
            + {8'd0, xin};
        lo  = {1'b0, dec_item.item.source_value[3:0]} + {1'b0, dec_item.item.dest_value[3:0]}
            + {4'd0, xin};
        if (lo > 5'd9) begin
          bcarry = 1'b1;
          lo = lo - 5'd10;
        end
        hi = {2'b00, dec_item.item.source_value[7:4]} + {2'b00, dec_item.item.dest_value[7:4]}
           + {5'd0, bcarry};
        if (lo >= 5'd16) begin
          lo = lo - 5'd16;
          hi = hi + 6'd1;
        end
        bcarry = 1'b0;
        if (hi > 6'd9) begin
          bcarry = 1'b1;
          hi = hi - 6'd10;
        end
        rm = {24'd0, hi[3:0], lo[3:0]};
        sr_next[alu_pkg::FN] = rm[7];
        sr_next[alu_pkg::FC] = bcarry;
        sr_next[alu_pkg::FX] = bcarry;
        sr_next[alu_pkg::FV] = ~bin[7] & rm[7];
        if (rm[7:0] != 8'd0) sr_next[alu_pkg::FZ] = 1'b0;
        res_next.result_write = 1'b1;
      end
      alu_pkg::OP_ADD, alu_pkg::OP_ADDQ, alu_pkg::OP_ADDX: begin
        if (dec_item.item.operation == alu_pkg::OP_ADDQ) begin
          s = dec_item.item.immediate_data == 16'd0 ? 32'd8
            : {16'd0, dec_item.item.immediate_data};
        end
        sum = {1'b0, s} + {1'b0, d}
            + {32'd0, dec_item.item.operation == alu_pkg::OP_ADDX && xin};
        r  = sum[31:0];
        rm = r & m;
        res_next.result_write = 1'b1;
        if (!(dec_item.item.operation == alu_pkg::OP_ADDQ &&
              dec_item.item.dest_kind == alu_pkg::DK_AREG)) begin
          bcarry = sum[32] || ((r & ~m) != 32'd0);
          sr_next[alu_pkg::FN] = (r & t) != 32'd0;
          sr_next[alu_pkg::FC] = bcarry;
          sr_next[alu_pkg::FX] = bcarry;
          sr_next[alu_pkg::FV] = ((s ^ r) & (d ^ r) & t) != 32'd0;
          if (dec_item.item.operation == alu_pkg::OP_ADDX) begin
            if (rm != 32'd0) sr_next[alu_pkg::FZ] = 1'b0;
          end else begin
            sr_next[alu_pkg::FZ] = rm == 32'd0;
          end
        end
      end
      alu_pkg::OP_AND, alu_pkg::OP_EOR: begin
        rm = dec_item.item.operation == alu_pkg::OP_AND ? (s & d) : (s ^ d);
        res_next.result_write = 1'b1;
        sr_next[alu_pkg::FN] = (rm & t) != 32'd0;
        sr_next[alu_pkg::FZ] = rm == 32'd0;
        sr_next[alu_pkg::FV] = 1'b0;
        sr_next[alu_pkg::FC] = 1'b0;
      end
      alu_pkg::OP_ADDA: begin
        adda_src = dec_item.item.size_code == alu_pkg::SZ_WORD
                 ? {{16{dec_item.item.source_value[15]}}, dec_item.item.source_value[15:0]}
                 : dec_item.item.source_value;
        rm = adda_src + dec_item.item.dest_value;
        res_next.result_write = 1'b1;
      end
      alu_pkg::OP_ANDCC: begin
        sr_next = {sr[15:8], sr[7:0] & dec_item.item.source_value[7:0]};
      end
      alu_pkg::OP_ANDSR: begin
        sr_next = sr & dec_item.item.source_value[15:0];
      end
      alu_pkg::OP_BCC, alu_pkg::OP_BSR: begin
        unique case (dec_item.item.condition_code)
          4'd0:  cond = 1'b1;
          4'd1:  cond = 1'b0;
          4'd2:  cond = !sr[alu_pkg::FC] && !sr[alu_pkg::FZ];
          4'd3:  cond = sr[alu_pkg::FC] || sr[alu_pkg::FZ];
          4'd4:  cond = !sr[alu_pkg::FC];
          4'd5:  cond = sr[alu_pkg::FC];
          4'd6:  cond = !sr[alu_pkg::FZ];
          4'd7:  cond = sr[alu_pkg::FZ];
          4'd8:  cond = !sr[alu_pkg::FV];
          4'd9:  cond = sr[alu_pkg::FV];
          4'd10: cond = !sr[alu_pkg::FN];
          4'd11: cond = sr[alu_pkg::FN];
          4'd12: cond = sr[alu_pkg::FN] == sr[alu_pkg::FV];
          4'd13: cond = sr[alu_pkg::FN] != sr[alu_pkg::FV];
          4'd14: cond = !sr[alu_pkg::FZ] && (sr[alu_pkg::FN] == sr[alu_pkg::FV]);
          default: cond = sr[alu_pkg::FZ] || (sr[alu_pkg::FN] != sr[alu_pkg::FV]);
        endcase
        if (dec_item.item.operation == alu_pkg::OP_BSR || cond) begin
          off = dec_item.item.size_code == alu_pkg::SZ_BYTE
              ? {{24{dec_item.item.immediate_data[7]}}, dec_item.item.immediate_data[7:0]}
              : {{16{dec_item.item.immediate_data[15]}}, dec_item.item.immediate_data}
                - 32'd2;
          res_next.next_pc      = dec_item.item.program_counter + off;
          res_next.branch_taken = 1'b1;
          res_next.unaligned_pc = res_next.next_pc[0];
        end
      end
      alu_pkg::OP_BTST, alu_pkg::OP_BCHG, alu_pkg::OP_BCLR, alu_pkg::OP_BSET: begin
        unique case (dec_item.item.operation)
          alu_pkg::OP_BCHG: nv = val ^ bitm;
          alu_pkg::OP_BCLR: nv = val & ~bitm;
          alu_pkg::OP_BSET: nv = val | bitm;
          default:          nv = val;
        endcase
        sr_next[alu_pkg::FZ] = (val & bitm) == 32'd0;
        rm = nv;
        res_next.result_write = nv != val;
      end
      alu_pkg::OP_CLR, alu_pkg::OP_NEG, alu_pkg::OP_NEGX, alu_pkg::OP_NOT: begin
        unique case (dec_item.item.operation)
          alu_pkg::OP_CLR:  r = 32'd0;
          alu_pkg::OP_NOT:  r = ~d;
          alu_pkg::OP_NEGX: r = 32'd0 - d - {31'd0, xin};
          default:          r = 32'd0 - d;
        endcase
        rm = r & m;
        zero_r = rm == 32'd0;
        res_next.result_write = 1'b1;
        sr_next[alu_pkg::FN] = (r & t) != 32'd0;
        if (dec_item.item.operation != alu_pkg::OP_NEGX || !zero_r) begin
          sr_next[alu_pkg::FZ] = zero_r;
        end
        if (dec_item.item.operation == alu_pkg::OP_NEG ||
            dec_item.item.operation == alu_pkg::OP_NEGX) begin
          bcarry = d != 32'd0 || (dec_item.item.operation == alu_pkg::OP_NEGX && xin);
          sr_next[alu_pkg::FV] = (d & r & t) != 32'd0;
          sr_next[alu_pkg::FC] = bcarry;
          sr_next[alu_pkg::FX] = bcarry;
        end else begin
          sr_next[alu_pkg::FV] = 1'b0;
          sr_next[alu_pkg::FC] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res_next.result_value = rm;
    res_next.status_out   = sr_next;
  end

  // take one item from the queue whenever the back part is idle
  assign dec_take = (state == ST_IDLE) && dec_valid;
  assign empty    = (state != ST_OUT);
  assign out_item = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sr    <= 16'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (dec_valid) begin
            if (dec_item.op_class == alu_pkg::CL_SHIFT) begin
              cur     <= dec_item;
              sh_val  <= dec_item.item.dest_value & dec_item.mask;
              sh_left <= dec_item.shift_count;
              sh_ov   <= 1'b0;
              sh_last <= 1'b0;
              state   <= ST_SHIFT;
            end else begin
              res   <= res_next;
              sr    <= sr_next;
              state <= ST_OUT;
            end
          end
        end
        ST_SHIFT: begin
          if (sh_left != 6'd0) begin
            sh_last <= (cur.item.operation == alu_pkg::OP_ASL ||
                        cur.item.operation == alu_pkg::OP_LSL)
                     ? ((sh_val[31:0] & cur.top) != 32'd0) : sh_val[0];
            if (nmsb != ((sh_val[31:0] & cur.top) != 32'd0)) sh_ov <= 1'b1;
            sh_val  <= nshift;
            sh_left <= sh_left - 6'd1;
          end else begin
            res.result_value <= sh_val[31:0];
            res.result_write <= 1'b1;
            res.next_pc      <= cur.item.program_counter;
            res.branch_taken <= 1'b0;
            res.unaligned_pc <= 1'b0;
            res.status_out   <= {sr[15:5],
                                 (cur.shift_count == 6'd0) ? sr[alu_pkg::FX] : sh_last,
                                 (sh_val[31:0] & cur.top) != 32'd0,
                                 sh_val[31:0] == 32'd0,
                                 (cur.item.operation == alu_pkg::OP_ASL ||
                                  cur.item.operation == alu_pkg::OP_ASR) && sh_ov,
                                 (cur.shift_count == 6'd0) ? 1'b0 : sh_last};
            sr <= {sr[15:5],
                   (cur.shift_count == 6'd0) ? sr[alu_pkg::FX] : sh_last,
                   (sh_val[31:0] & cur.top) != 32'd0,
                   sh_val[31:0] == 32'd0,
                   (cur.item.operation == alu_pkg::OP_ASL ||
                    cur.item.operation == alu_pkg::OP_ASR) && sh_ov,
                   (cur.shift_count == 6'd0) ? 1'b0 : sh_last};
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (pop) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/cpu_integer_alu_with_flags.sv */
// Flow: an accepted push is written into the queue, then the back part registers
//   the result for most operations; shifts first step through the bit-serial
//   shifter (an immediate low-byte count above 63 is capped at 63).
// Occupancy: the single execute unit holds its result until popped and takes
//   no new item before then; a shift also holds it while the shifter steps.
// Reset: synchronous, clears the status register, the queue and the
//   execute state; payload registers are not reset.
// ----------------------------------------------------------------------------
// cpu_integer_alu_with_flags: 68000-style execute stage with X N Z V C flags
// A front part classifies items into a two-entry queue; the back part runs
// them against the status register and presents one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_integer_alu_with_flags (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire alu_pkg::in_item_t  in_item,
  input  wire logic               push,
  output logic                    full,
  output alu_pkg::out_item_t      out_item,
  output logic                    empty,
  input  wire logic               pop
);

  // classified items waiting for the execute unit
  alu_pkg::dec_item_t dec_item;
  logic               dec_valid;
  logic               dec_take;

  // front: accept a transfer and classify it
  alu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .push      (push),
    .full      (full),
    .dec_item  (dec_item),
    .dec_valid (dec_valid),
    .dec_take  (dec_take)
  );

  // back: execute, update flags, hold the result until popped
  alu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dec_item  (dec_item),
    .dec_valid (dec_valid),
    .dec_take  (dec_take),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 68000-style integer ALU with flags
// Drives directed and random instructions through the push/full queue side,
// predicts every result and the status register chain, and checks each
// popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 900;

  logic               clk;
  logic               rst;
  alu_pkg::in_item_t  in_item;
  logic               push;
  logic               full;
  alu_pkg::out_item_t out_item;
  logic               empty;
  logic               pop;

  cpu_integer_alu_with_flags dut (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: the status register as the block should hold it.
  logic [15:0]        sr_model;
  alu_pkg::out_item_t expected_results[$];
  int                 errors;
  int                 idle_cycles;

  // Directed rows: an instruction and, where obvious, its typed-in result.
  typedef struct {
    alu_pkg::in_item_t  item;
    bit                 has_fixed;
    alu_pkg::out_item_t fixed;
  } stim_row_t;
  stim_row_t directed_rows[$];

  function automatic logic cond_true(logic [3:0] cc, logic [15:0] sr);
    logic c, v, z, n;
    c = sr[alu_pkg::FC]; v = sr[alu_pkg::FV]; z = sr[alu_pkg::FZ]; n = sr[alu_pkg::FN];
    case (cc)
      4'd0:  return 1'b1;
      4'd1:  return 1'b0;
      4'd2:  return !c && !z;
      4'd3:  return c || z;
      4'd4:  return !c;
      4'd5:  return c;
      4'd6:  return !z;
      4'd7:  return z;
      4'd8:  return !v;
      4'd9:  return v;
      4'd10: return !n;
      4'd11: return n;
      4'd12: return n == v;
      4'd13: return n != v;
      4'd14: return !z && (n == v);
      default: return z || (n != v);
    endcase
  endfunction

  // Execute one instruction against sr_model and return its result.
  function automatic alu_pkg::out_item_t execute_insn(alu_pkg::in_item_t it);
    alu_pkg::out_item_t o;
    int unsigned nb, cnt;
    logic [63:0] m, top, s, d, r, a;
    logic [7:0]  s8, d8, res8;
    logic [4:0]  lo;
    logic [5:0]  hi;
    logic [8:0]  bin;
    logic        x, carry, ov, cur, last, nm, arith, left, dreg, borrow;
    logic [31:0] val, nv, bitm, off;
    logic [4:0]  bn;
    nb   = it.size_code == alu_pkg::SZ_BYTE ? 8 : (it.size_code == alu_pkg::SZ_WORD ? 16 : 32);
    m    = (64'd1 << nb) - 64'd1;
    top  = 64'd1 << (nb - 1);
    s    = {32'd0, it.source_value} & m;
    d    = {32'd0, it.dest_value} & m;
    r    = '0;
    o    = '0;
    o.next_pc = it.program_counter;
    x    = sr_model[alu_pkg::FX];
    case (it.operation)
      alu_pkg::OP_ABCD: begin
        s8 = it.source_value[7:0]; d8 = it.dest_value[7:0];
        bin = s8 + d8 + x;
        carry = 1'b0;
        lo = s8[3:0] + d8[3:0] + x;
        if (lo > 5'd9) begin carry = 1'b1; lo = lo - 5'd10; end
        hi = s8[7:4] + d8[7:4] + carry;
        carry = 1'b0;
        if (lo >= 5'd16) begin lo = lo - 5'd16; hi = hi + 6'd1; end
        if (hi > 6'd9) begin carry = 1'b1; hi = hi - 6'd10; end
        res8 = (hi << 4) + lo;
        sr_model[alu_pkg::FN] = res8[7];
        sr_model[alu_pkg::FC] = carry;
        sr_model[alu_pkg::FX] = carry;
        sr_model[alu_pkg::FV] = ~bin[7] & res8[7];
        if (res8 != 0) sr_model[alu_pkg::FZ] = 1'b0;
        r = {56'd0, res8}; o.result_write = 1'b1;
      end
      alu_pkg::OP_ADD, alu_pkg::OP_ADDQ, alu_pkg::OP_ADDX: begin
        if (it.operation == alu_pkg::OP_ADDQ)
          s = it.immediate_data != 16'd0 ? {48'd0, it.immediate_data} : 64'd8;
        r = s + d + ((it.operation == alu_pkg::OP_ADDX && x) ? 64'd1 : 64'd0);
        o.result_write = 1'b1;
        if (!(it.operation == alu_pkg::OP_ADDQ && it.dest_kind == alu_pkg::DK_AREG)) begin
          carry = (r & ~m) != 0;
          sr_model[alu_pkg::FN] = (r & top) != 0;
          sr_model[alu_pkg::FC] = carry;
          sr_model[alu_pkg::FX] = carry;
          sr_model[alu_pkg::FV] = ((s ^ r) & (d ^ r) & top) != 0;
          if (it.operation == alu_pkg::OP_ADDX) begin
            if ((r & m) != 0) sr_model[alu_pkg::FZ] = 1'b0;
          end else begin
            sr_model[alu_pkg::FZ] = (r & m) == 0;
          end
        end
      end
      alu_pkg::OP_AND, alu_pkg::OP_EOR: begin
        r = it.operation == alu_pkg::OP_AND ? (s & d) : (s ^ d);
        o.result_write = 1'b1;
        sr_model[alu_pkg::FN] = (r & top) != 0;
        sr_model[alu_pkg::FZ] = (r & m) == 0;
        sr_model[alu_pkg::FV] = 1'b0;
        sr_model[alu_pkg::FC] = 1'b0;
      end
      alu_pkg::OP_ADDA: begin
        a = it.size_code == alu_pkg::SZ_WORD
          ? {{48{it.source_value[15]}}, it.source_value[15:0]}
          : {32'd0, it.source_value};
        r = (a + {32'd0, it.dest_value}) & 64'hFFFF_FFFF;
        m = 64'hFFFF_FFFF;
        o.result_write = 1'b1;
      end
      alu_pkg::OP_ANDCC:
        sr_model = {sr_model[15:8], sr_model[7:0] & it.source_value[7:0]};
      alu_pkg::OP_ANDSR: sr_model = sr_model & it.source_value[15:0];
      alu_pkg::OP_ASL, alu_pkg::OP_ASR, alu_pkg::OP_LSL, alu_pkg::OP_LSR: begin
        arith = it.operation == alu_pkg::OP_ASL || it.operation == alu_pkg::OP_ASR;
        left  = it.operation == alu_pkg::OP_ASL || it.operation == alu_pkg::OP_LSL;
        cnt = it.count_from_register ? it.source_value[5:0]
            : (it.immediate_data != 16'd0 ? it.immediate_data[7:0] : 8);
        ov = 1'b0; last = 1'b0;
        r = d;
        cur = (r & top) != 0;
        for (int unsigned i = 0; i < cnt; i++) begin
          if (left) begin
            last = (r & top) != 0; r = r << 1;
          end else begin
            last = r[0];
            r = arith ? ((r >> 1) | (r & top)) : (r >> 1);
          end
          nm = (r & top) != 0;
          if (nm != cur) ov = 1'b1;
          cur = nm;
        end
        o.result_write = 1'b1;
        sr_model[alu_pkg::FN] = (r & top) != 0;
        sr_model[alu_pkg::FZ] = (r & m) == 0;
        sr_model[alu_pkg::FV] = arith && ov;
        if (cnt == 0) sr_model[alu_pkg::FC] = 1'b0;
        else begin
          sr_model[alu_pkg::FX] = last; sr_model[alu_pkg::FC] = last;
        end
      end
      alu_pkg::OP_BCC, alu_pkg::OP_BSR: begin
        if (it.operation == alu_pkg::OP_BSR || cond_true(it.condition_code, sr_model)) begin
          off = it.size_code == alu_pkg::SZ_BYTE
              ? {{24{it.immediate_data[7]}}, it.immediate_data[7:0]}
              : {{16{it.immediate_data[15]}}, it.immediate_data} - 32'd2;
          o.next_pc = it.program_counter + off;
          o.branch_taken = 1'b1;
          o.unaligned_pc = o.next_pc[0];
        end
      end
      alu_pkg::OP_BTST, alu_pkg::OP_BCHG, alu_pkg::OP_BCLR, alu_pkg::OP_BSET: begin
        dreg = it.dest_kind == alu_pkg::DK_DREG;
        bn   = dreg ? it.source_value[4:0] : {2'b00, it.source_value[2:0]};
        val  = dreg ? it.dest_value : {24'd0, it.dest_value[7:0]};
        bitm = 32'd1 << bn;
        nv   = val;
        if (it.operation == alu_pkg::OP_BCHG) nv = nv ^ bitm;
        else if (it.operation == alu_pkg::OP_BCLR) nv = nv & ~bitm;
        else if (it.operation == alu_pkg::OP_BSET) nv = nv | bitm;
        sr_model[alu_pkg::FZ] = (val & bitm) == 0;
        r = {32'd0, nv};
        m = 64'hFFFF_FFFF;
        o.result_write = nv != val;
      end
      alu_pkg::OP_CLR, alu_pkg::OP_NEG, alu_pkg::OP_NEGX, alu_pkg::OP_NOT: begin
        if (it.operation == alu_pkg::OP_CLR) r = 0;
        else if (it.operation == alu_pkg::OP_NOT) r = ~d;
        else r = 64'd0 - d - ((it.operation == alu_pkg::OP_NEGX) ? {63'd0, x} : 64'd0);
        o.result_write = 1'b1;
        sr_model[alu_pkg::FN] = (r & top) != 0;
        if (it.operation != alu_pkg::OP_NEGX || (r & m) != 0)
          sr_model[alu_pkg::FZ] = (r & m) == 0;
        if (it.operation == alu_pkg::OP_NEG || it.operation == alu_pkg::OP_NEGX) begin
          borrow = d != 0 || (it.operation == alu_pkg::OP_NEGX && x);
          sr_model[alu_pkg::FV] = (d & r & top) != 0;
          sr_model[alu_pkg::FC] = borrow;
          sr_model[alu_pkg::FX] = borrow;
        end else begin
          sr_model[alu_pkg::FV] = 1'b0;
          sr_model[alu_pkg::FC] = 1'b0;
        end
      end
      default: ;
    endcase
    o.result_value = r[31:0] & m[31:0];
    o.status_out   = sr_model;
    return o;
  endfunction

  function automatic alu_pkg::in_item_t make_insn(logic [4:0] op, logic [1:0] sz,
                                                  logic [31:0] src, logic [31:0] dst,
                                                  logic [15:0] imm);
    alu_pkg::in_item_t it;
    it = '0;
    it.operation = op; it.size_code = sz; it.source_value = src;
    it.dest_value = dst; it.immediate_data = imm;
    it.program_counter = 32'h0000_1000;
    return it;
  endfunction

  function automatic alu_pkg::in_item_t random_insn();
    alu_pkg::in_item_t it;
    it.operation           = ($urandom_range(0, 25) <= 23) ? 5'($urandom_range(0, 23))
                                                            : 5'($urandom);
    it.size_code           = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.source_value        = $urandom;
    it.dest_value          = $urandom;
    it.count_from_register = 1'($urandom);
    it.immediate_data      = 16'($urandom);
    it.condition_code      = 4'($urandom);
    it.program_counter     = $urandom;
    it.dest_kind           = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    // Keep most shifts short; the block is bit-serial.
    if ($urandom_range(0, 3) != 0) begin
      it.source_value[5:0]   = 6'($urandom_range(0, 9));
      it.immediate_data[7:0] = 8'($urandom_range(0, 9));
    end
    // Bias values toward the edges of each size to hit carries and overflow.
    case ($urandom_range(0, 5))
      0: it.dest_value = 32'h0;
      1: it.dest_value = 32'hFFFF_FFFF;
      2: it.source_value = 32'h8000_8080;
      default: ;
    endcase
    return it;
  endfunction

  // Record the prediction for an accepted transfer.
  task automatic log_transfer(alu_pkg::in_item_t it, bit has_fixed,
                              alu_pkg::out_item_t fixed);
    alu_pkg::out_item_t p;
    p = execute_insn(it);
    if (has_fixed && p !== fixed) begin
      $error("directed row: exp %h act %h", fixed, p);
      errors++;
    end
    expected_results.push_back(p);
  endtask

  // Drop push only across a gap, so back-to-back items keep it high.
  task automatic send_insn(alu_pkg::in_item_t it, bit has_fixed, alu_pkg::out_item_t fixed);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    push    <= 1'b1;
    // Hold push until the queue takes the transfer.
    do @(posedge clk); while (full);
    log_transfer(it, has_fixed, fixed);
  endtask

  // Result side: random pop stalls, check each transfer on acceptance.
  initial begin
    alu_pkg::out_item_t e;
    int stall;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_results.size() == 0) begin
        $error("result with no instruction outstanding: %h", out_item);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.result_value !== e.result_value) begin
          $error("result_value exp %h act %h", e.result_value, out_item.result_value);
          errors++;
        end
        if (out_item.result_write !== e.result_write) begin
          $error("result_write exp %b act %b", e.result_write, out_item.result_write);
          errors++;
        end
        if (out_item.next_pc !== e.next_pc) begin
          $error("next_pc exp %h act %h", e.next_pc, out_item.next_pc);
          errors++;
        end
        if (out_item.branch_taken !== e.branch_taken) begin
          $error("branch_taken exp %b act %b", e.branch_taken, out_item.branch_taken);
          errors++;
        end
        if (out_item.unaligned_pc !== e.unaligned_pc) begin
          $error("unaligned_pc exp %b act %b", e.unaligned_pc, out_item.unaligned_pc);
          errors++;
        end
        if (out_item.status_out !== e.status_out) begin
          $error("status_out exp %h act %h", e.status_out, out_item.status_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic add_row(alu_pkg::in_item_t it, bit has_fixed, logic [31:0] rv, logic wr,
                         logic [15:0] sr);
    stim_row_t row;
    row.item = it;
    row.has_fixed = has_fixed;
    row.fixed = '0;
    row.fixed.result_value = rv;
    row.fixed.result_write = wr;
    row.fixed.next_pc = it.program_counter;
    row.fixed.status_out = sr;
    directed_rows.push_back(row);
  endtask

  initial begin
    alu_pkg::in_item_t  it;
    alu_pkg::out_item_t none;
    none = '0;
    errors = 0;
    sr_model = '0;
    rst = 1'b1; push = 1'b0; in_item = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; rows with typed-in results come first from reset.
    add_row(make_insn(alu_pkg::OP_NOP, alu_pkg::SZ_BYTE, 0, 0, 0), 1, 32'h0, 1'b0, 16'h0000);
    add_row(make_insn(alu_pkg::OP_ADD, alu_pkg::SZ_BYTE, 32'hFF, 32'h01, 0), 1, 32'h0, 1'b1,
            16'h0015);
    add_row(make_insn(alu_pkg::OP_CLR, 2'd2, 0, 32'hFFFF_FFFF, 0), 1, 32'h0, 1'b1, 16'h0014);
    add_row(make_insn(alu_pkg::OP_ANDSR, alu_pkg::SZ_WORD, 32'h0, 0, 0), 1, 32'h0, 1'b0,
            16'h0000);
    add_row(make_insn(alu_pkg::OP_ADD, 2'd2, 32'h7FFF_FFFF, 32'h1, 0), 1, 32'h8000_0000, 1'b1,
            16'h000A);
    add_row(make_insn(alu_pkg::OP_ADD, alu_pkg::SZ_WORD, 32'hFFFF, 32'hFFFF, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ABCD, alu_pkg::SZ_BYTE, 32'h99, 32'h01, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ABCD, alu_pkg::SZ_BYTE, 32'hFF, 32'hFF, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ADDX, alu_pkg::SZ_BYTE, 32'h00, 32'h00, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_AND, 2'd3, 32'hF0F0_F0F0, 32'hFFFF_0000, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_EOR, alu_pkg::SZ_WORD, 32'hFFFF, 32'hFFFF, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ADDA, alu_pkg::SZ_WORD, 32'h8000, 32'h1000, 0), 0, 0, 0, 0);
    it = make_insn(alu_pkg::OP_ADDQ, 2'd2, 0, 32'hFFFF_FFF8, 0);
    it.dest_kind = alu_pkg::DK_AREG;
    add_row(it, 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ADDQ, alu_pkg::SZ_BYTE, 0, 32'hF8, 16'h0000), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ANDCC, alu_pkg::SZ_BYTE, 32'hEF, 0, 0), 0, 0, 0, 0);
    it = make_insn(alu_pkg::OP_ASL, alu_pkg::SZ_BYTE, 32'd63, 32'h40, 0);
    it.count_from_register = 1;
    add_row(it, 0, 0, 0, 0);
    it = make_insn(alu_pkg::OP_ASR, alu_pkg::SZ_WORD, 32'd0, 32'h8001, 0);
    it.count_from_register = 1;
    add_row(it, 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_LSL, 2'd2, 0, 32'h8000_0001, 16'h0000), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_LSL, 2'd2, 0, 32'h8000_0001, 16'h0100), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_ASR, 2'd2, 0, 32'h8000_0001, 16'h00C8), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_LSR, alu_pkg::SZ_BYTE, 0, 32'h81, 16'hFF01), 0, 0, 0, 0);
    it = make_insn(alu_pkg::OP_BCC, alu_pkg::SZ_BYTE, 0, 0, 16'h0081);
    it.condition_code = 4'd0;
    add_row(it, 0, 0, 0, 0);
    it = make_insn(alu_pkg::OP_BCC, alu_pkg::SZ_WORD, 0, 0, 16'h8000);
    it.condition_code = 4'd1;
    add_row(it, 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_BSR, alu_pkg::SZ_WORD, 0, 0, 16'h7FFF), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_BTST, alu_pkg::SZ_BYTE, 32'd31, 32'h8000_0000, 0),
            0, 0, 0, 0);
    it = make_insn(alu_pkg::OP_BCHG, alu_pkg::SZ_BYTE, 32'hFF, 32'hFFFF_FF80, 0);
    it.dest_kind = 2'd2;
    add_row(it, 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_BCLR, alu_pkg::SZ_BYTE, 32'd3, 32'h0, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_BSET, alu_pkg::SZ_BYTE, 32'd33, 32'h0, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_NEG, alu_pkg::SZ_BYTE, 0, 32'h80, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_NEGX, alu_pkg::SZ_WORD, 0, 32'h0, 0), 0, 0, 0, 0);
    add_row(make_insn(alu_pkg::OP_NOT, 2'd2, 0, 32'h0, 0), 0, 0, 0, 0);
    add_row(make_insn(5'd31, alu_pkg::SZ_BYTE, 0, 0, 0), 0, 0, 0, 0);

    foreach (directed_rows[i])
      send_insn(directed_rows[i].item, directed_rows[i].has_fixed, directed_rows[i].fixed);

    // Random part: mostly valid instructions, edge-biased operands.
    repeat (RANDOM_ITEMS) send_insn(random_insn(), 0, none);
    push <= 1'b0;

    // Drain, then allow the longest shift to settle.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
